>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EHI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define EHI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ehi_pkg.sv
// Shared types, constants and command codes of the extendible hash index.
package ehi_pkg;

    localparam int SLOTS         = 64;
    localparam int DIR_ENTRIES   = 1024;
    localparam int KEY_BYTES     = 19;
    localparam int SLOT_BITS     = $clog2(SLOTS);
    localparam int DIR_BITS      = $clog2(DIR_ENTRIES);
    localparam int CNT_BITS      = $clog2(SLOTS + 1);
    localparam int GD_BITS       = $clog2(DIR_BITS + 1);
    localparam int BC_BITS       = DIR_BITS + 1;
    localparam int ADDR_BITS     = DIR_BITS + SLOT_BITS;
    localparam int STORE_DEPTH   = DIR_ENTRIES * SLOTS;
    localparam int KEY_W         = 152;
    localparam int BYTE_IDX_BITS = $clog2(KEY_BYTES);

    localparam logic [63:0] HASH_SEED = 64'd5381;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_SEARCH,
        OP_REMOVE,
        OP_UPDATE
    } ehi_op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MISS,
        ST_FULL
    } ehi_status_t;

    typedef struct packed {
        ehi_op_t     op;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [23:0] key_word2;
        logic [31:0] payload;
    } ehi_req_t;

    typedef struct packed {
        ehi_status_t status;
        logic [31:0] payload_out;
    } ehi_rsp_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_INIT0,
        CMD_INIT1,
        CMD_LOAD,
        CMD_HASH_STEP,
        CMD_DIR_RD,
        CMD_BKT,
        CMD_META,
        CMD_INS_WR,
        CMD_NOTFOUND,
        CMD_SCAN_RD,
        CMD_NEXT,
        CMD_FOUND,
        CMD_RM_WR,
        CMD_FULL,
        CMD_DBL_START,
        CMD_DBL_RD,
        CMD_DBL_WR,
        CMD_DBL_END,
        CMD_NEW,
        CMD_NEW2,
        CMD_SLOT_LOAD,
        CMD_MOVE,
        CMD_EC_B,
        CMD_EC_N,
        CMD_SW_RD,
        CMD_SW_WR,
        CMD_OUT
    } ehi_cmd_t;

    typedef struct packed {
        logic hash_last;
        logic match;
        logic room;
        logic scan_end;
        logic ld_ge_gd;
        logic gd_max;
        logic bc_full;
        logic i_end;
        logic is_insert;
        logic is_remove;
    } ehi_stat_t;

endpackage

>>> rtl/ehi_ctrl.sv
// Sequencer of the hash index: walks each transaction through hash, lookup and split.
module ehi_ctrl import ehi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  ehi_stat_t stat,
    output ehi_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_HASH, S_DIR, S_BKT, S_META, S_INS,
        S_SPLIT_CHK, S_DBL_RD, S_DBL_WR, S_NEW, S_NEW2, S_RD_SLOT,
        S_LD_SLOT, S_SH, S_MOVE, S_EC_N, S_SW_RD, S_SW_WR, S_SCAN,
        S_CMP, S_RM, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NOP;
        unique case (state_reg)
            S_INIT0:
            begin
                cmd        = CMD_INIT0;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                cmd        = CMD_INIT1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd = CMD_HASH_STEP;
                if (stat.hash_last)
                    state_next = S_DIR;
            end
            S_DIR:
            begin
                cmd        = CMD_DIR_RD;
                state_next = S_BKT;
            end
            S_BKT:
            begin
                cmd        = CMD_BKT;
                state_next = S_META;
            end
            S_META:
            begin
                cmd        = CMD_META;
                state_next = stat.is_insert ? S_INS : S_SCAN;
            end
            S_INS:
            begin
                if (stat.room)
                begin
                    cmd        = CMD_INS_WR;
                    state_next = S_OUT;
                end
                else
                    state_next = S_SPLIT_CHK;
            end
            S_SPLIT_CHK:
            begin
                priority if (stat.ld_ge_gd && (stat.gd_max || stat.bc_full))
                begin
                    cmd        = CMD_FULL;
                    state_next = S_OUT;
                end
                else if (stat.ld_ge_gd)
                begin
                    cmd        = CMD_DBL_START;
                    state_next = S_DBL_RD;
                end
                else if (stat.bc_full)
                begin
                    cmd        = CMD_FULL;
                    state_next = S_OUT;
                end
                else
                    state_next = S_NEW;
            end
            S_DBL_RD:
            begin
                if (stat.i_end)
                begin
                    cmd        = CMD_DBL_END;
                    state_next = S_NEW;
                end
                else
                begin
                    cmd        = CMD_DBL_RD;
                    state_next = S_DBL_WR;
                end
            end
            S_DBL_WR:
            begin
                cmd        = CMD_DBL_WR;
                state_next = S_DBL_RD;
            end
            S_NEW:
            begin
                cmd        = CMD_NEW;
                state_next = S_NEW2;
            end
            S_NEW2:
            begin
                cmd        = CMD_NEW2;
                state_next = S_RD_SLOT;
            end
            S_RD_SLOT:
            begin
                if (stat.scan_end)
                begin
                    cmd        = CMD_EC_B;
                    state_next = S_EC_N;
                end
                else
                begin
                    cmd        = CMD_SCAN_RD;
                    state_next = S_LD_SLOT;
                end
            end
            S_LD_SLOT:
            begin
                cmd        = CMD_SLOT_LOAD;
                state_next = S_SH;
            end
            S_SH:
            begin
                cmd = CMD_HASH_STEP;
                if (stat.hash_last)
                    state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd        = CMD_MOVE;
                state_next = S_RD_SLOT;
            end
            S_EC_N:
            begin
                cmd        = CMD_EC_N;
                state_next = S_SW_RD;
            end
            S_SW_RD:
            begin
                if (stat.i_end)
                    state_next = S_DIR;
                else
                begin
                    cmd        = CMD_SW_RD;
                    state_next = S_SW_WR;
                end
            end
            S_SW_WR:
            begin
                cmd        = CMD_SW_WR;
                state_next = S_SW_RD;
            end
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    cmd        = CMD_NOTFOUND;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd        = CMD_SCAN_RD;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    cmd        = CMD_FOUND;
                    state_next = stat.is_remove ? S_RM : S_OUT;
                end
                else
                begin
                    cmd        = CMD_NEXT;
                    state_next = S_SCAN;
                end
            end
            S_RM:
            begin
                cmd        = CMD_RM_WR;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd        = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd == CMD_OUT)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> rtl/ehi_dp.sv
// Datapath of the hash index: hash unit, directory, bucket tables and slot store.
module ehi_dp import ehi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ehi_cmd_t  cmd,
    input  ehi_req_t  req,
    output ehi_stat_t stat,
    output ehi_rsp_t  rsp
);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [31:0]      dref;
    } slot_t;

    logic [DIR_BITS-1:0] dir_mem   [DIR_ENTRIES];
    logic [GD_BITS-1:0]  ld_mem    [DIR_ENTRIES];
    logic [CNT_BITS-1:0] ec_mem    [DIR_ENTRIES];
    slot_t               store_mem [STORE_DEPTH];

    logic [DIR_BITS-1:0] dir_q;
    logic [GD_BITS-1:0]  ld_q;
    logic [CNT_BITS-1:0] ec_q;
    slot_t               store_q;

    ehi_op_t                op_reg;
    logic [KEY_W-1:0]       key_reg, hk_reg, nk_reg;
    logic [31:0]            pay_reg;
    logic [63:0]            hacc_reg, h_reg;
    logic [BYTE_IDX_BITS-1:0] idx_reg;
    logic                   ended_reg, hmode_reg;
    logic [GD_BITS-1:0]     gd_reg, ld_reg;
    logic [BC_BITS-1:0]     bc_reg, i_reg;
    logic [DIR_BITS-1:0]    b_reg, n_reg;
    logic [CNT_BITS-1:0]    ec_reg, s_reg, keep_reg, cntn_reg;
    ehi_status_t            st_reg;
    logic [31:0]            po_reg;
    slot_t                  mv_reg;
    ehi_rsp_t               rsp_reg;

    // hash step
    logic [7:0]       cur_byte, hb;
    logic [63:0]      hacc_step, hacc_nx;
    logic [KEY_W-1:0] nk_step;
    logic             hash_last;

    assign cur_byte  = hk_reg[{idx_reg, 3'b000} +: 8];
    assign hb        = ended_reg ? 8'd0 : cur_byte;
    assign hacc_step = (hacc_reg << 5) + hacc_reg + {56'd0, hb};
    assign hacc_nx   = (hb == 8'd0) ? hacc_reg : hacc_step;
    assign nk_step   = nk_reg | (KEY_W'(hb) << {idx_reg, 3'b000});
    assign hash_last = (idx_reg == BYTE_IDX_BITS'(KEY_BYTES - 1));

    // split helpers
    logic [BC_BITS-1:0]  size, size_m1, dbl_addr;
    logic [DIR_BITS-1:0] bitmask;
    logic                i_bit, h_bit;
    logic [CNT_BITS-1:0] ec_dec;

    assign size     = BC_BITS'(1) << gd_reg;
    assign size_m1  = size - BC_BITS'(1);
    assign dbl_addr = i_reg + size;
    assign bitmask  = DIR_BITS'(1) << (ld_reg - GD_BITS'(1));
    assign i_bit    = |(i_reg[DIR_BITS-1:0] & bitmask);
    assign h_bit    = |(hacc_reg[DIR_BITS-1:0] & bitmask);
    assign ec_dec   = ec_reg - CNT_BITS'(1);

    // memory ports
    logic [DIR_BITS-1:0]  dir_raddr, dir_waddr, dir_wdata;
    logic                 dir_we, ld_we, ec_we, st_we;
    logic [DIR_BITS-1:0]  ld_waddr, ec_waddr;
    logic [GD_BITS-1:0]   ld_wdata;
    logic [CNT_BITS-1:0]  ec_wdata;
    logic [ADDR_BITS-1:0] st_raddr, st_waddr;
    slot_t                st_wdata;

    always_comb
    begin
        dir_raddr = (cmd == CMD_DIR_RD) ? (h_reg[DIR_BITS-1:0] & size_m1[DIR_BITS-1:0])
                                        : i_reg[DIR_BITS-1:0];
        st_raddr  = (cmd == CMD_FOUND) ? {b_reg, ec_dec[SLOT_BITS-1:0]}
                                       : {b_reg, s_reg[SLOT_BITS-1:0]};
        dir_we    = 1'b0;
        dir_waddr = i_reg[DIR_BITS-1:0];
        dir_wdata = n_reg;
        ld_we     = 1'b0;
        ld_waddr  = b_reg;
        ld_wdata  = ld_reg;
        ec_we     = 1'b0;
        ec_waddr  = b_reg;
        ec_wdata  = keep_reg;
        st_we     = 1'b0;
        st_waddr  = {b_reg, s_reg[SLOT_BITS-1:0]};
        st_wdata  = store_q;
        unique case (cmd)
            CMD_INIT0, CMD_INIT1:
            begin
                dir_we    = 1'b1;
                dir_waddr = (cmd == CMD_INIT1) ? DIR_BITS'(1) : DIR_BITS'(0);
                dir_wdata = dir_waddr;
                ld_we     = 1'b1;
                ld_waddr  = dir_waddr;
                ld_wdata  = GD_BITS'(1);
                ec_we     = 1'b1;
                ec_waddr  = dir_waddr;
                ec_wdata  = '0;
            end
            CMD_DBL_WR:
            begin
                dir_we    = 1'b1;
                dir_waddr = dbl_addr[DIR_BITS-1:0];
                dir_wdata = dir_q;
            end
            CMD_SW_WR:
                dir_we = (dir_q == b_reg) && i_bit;
            CMD_NEW:
            begin
                ld_we    = 1'b1;
                ld_wdata = ld_reg + GD_BITS'(1);
            end
            CMD_NEW2:
            begin
                ld_we    = 1'b1;
                ld_waddr = n_reg;
            end
            CMD_INS_WR:
            begin
                ec_we    = 1'b1;
                ec_wdata = ec_reg + CNT_BITS'(1);
                st_we    = 1'b1;
                st_waddr = {b_reg, ec_reg[SLOT_BITS-1:0]};
                st_wdata = '{key: key_reg, dref: pay_reg};
            end
            CMD_RM_WR:
            begin
                ec_we    = 1'b1;
                ec_wdata = ec_dec;
                st_we    = 1'b1;
            end
            CMD_MOVE:
            begin
                st_we    = 1'b1;
                st_waddr = h_bit ? {n_reg, cntn_reg[SLOT_BITS-1:0]}
                                 : {b_reg, keep_reg[SLOT_BITS-1:0]};
                st_wdata = mv_reg;
            end
            CMD_EC_B:
                ec_we = 1'b1;
            CMD_EC_N:
            begin
                ec_we    = 1'b1;
                ec_waddr = n_reg;
                ec_wdata = cntn_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dir_we)
            dir_mem[dir_waddr] <= dir_wdata;
        dir_q <= dir_mem[dir_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ld_we)
            ld_mem[ld_waddr] <= ld_wdata;
        ld_q <= ld_mem[dir_q];
    end

    always_ff @(posedge clk)
    begin
        if (ec_we)
            ec_mem[ec_waddr] <= ec_wdata;
        ec_q <= ec_mem[dir_q];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        store_q <= store_mem[st_raddr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gd_reg   <= GD_BITS'(1);
            bc_reg   <= BC_BITS'(2);
            idx_reg  <= '0;
            i_reg    <= '0;
            s_reg    <= '0;
            keep_reg <= '0;
            cntn_reg <= '0;
        end
        else
        begin
            unique case (cmd)
                CMD_LOAD, CMD_SLOT_LOAD:
                    idx_reg <= '0;
                CMD_HASH_STEP:
                    idx_reg <= idx_reg + BYTE_IDX_BITS'(1);
                CMD_META:
                    s_reg <= '0;
                CMD_NEXT:
                    s_reg <= s_reg + CNT_BITS'(1);
                CMD_DBL_START, CMD_EC_N:
                    i_reg <= '0;
                CMD_DBL_WR, CMD_SW_WR:
                    i_reg <= i_reg + BC_BITS'(1);
                CMD_DBL_END:
                    gd_reg <= gd_reg + GD_BITS'(1);
                CMD_NEW:
                begin
                    bc_reg   <= bc_reg + BC_BITS'(1);
                    s_reg    <= '0;
                    keep_reg <= '0;
                    cntn_reg <= '0;
                end
                CMD_MOVE:
                begin
                    s_reg <= s_reg + CNT_BITS'(1);
                    if (h_bit)
                        cntn_reg <= cntn_reg + CNT_BITS'(1);
                    else
                        keep_reg <= keep_reg + CNT_BITS'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                op_reg    <= req.op;
                hk_reg    <= {req.key_word2, req.key_word1, req.key_word0};
                pay_reg   <= req.payload;
                hacc_reg  <= HASH_SEED;
                ended_reg <= 1'b0;
                nk_reg    <= '0;
                hmode_reg <= 1'b1;
            end
            CMD_SLOT_LOAD:
            begin
                mv_reg    <= store_q;
                hk_reg    <= store_q.key;
                hacc_reg  <= HASH_SEED;
                ended_reg <= 1'b0;
                nk_reg    <= '0;
                hmode_reg <= 1'b0;
            end
            CMD_HASH_STEP:
            begin
                hacc_reg  <= hacc_nx;
                nk_reg    <= nk_step;
                ended_reg <= ended_reg | (hb == 8'd0);
                if (hash_last && hmode_reg)
                begin
                    h_reg   <= hacc_nx;
                    key_reg <= nk_step;
                end
            end
            CMD_BKT:
                b_reg <= dir_q;
            CMD_META:
            begin
                ld_reg <= ld_q;
                ec_reg <= ec_q;
            end
            CMD_NEW:
            begin
                n_reg  <= bc_reg[DIR_BITS-1:0];
                ld_reg <= ld_reg + GD_BITS'(1);
            end
            CMD_INS_WR:
            begin
                st_reg <= ST_OK;
                po_reg <= '0;
            end
            CMD_NOTFOUND:
            begin
                st_reg <= ST_MISS;
                po_reg <= '0;
            end
            CMD_FULL:
            begin
                st_reg <= ST_FULL;
                po_reg <= '0;
            end
            CMD_FOUND:
            begin
                st_reg <= ST_OK;
                po_reg <= store_q.dref;
            end
            CMD_OUT:
                rsp_reg <= '{status: st_reg, payload_out: po_reg};
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.hash_last = hash_last;
        stat.match     = (store_q.key == key_reg);
        stat.room      = (ec_reg < CNT_BITS'(SLOTS));
        stat.scan_end  = (s_reg == ec_reg);
        stat.ld_ge_gd  = (ld_reg >= gd_reg);
        stat.gd_max    = (gd_reg >= GD_BITS'(DIR_BITS));
        stat.bc_full   = (bc_reg >= BC_BITS'(DIR_ENTRIES));
        stat.i_end     = (i_reg == size);
        stat.is_insert = (op_reg == OP_INSERT);
        stat.is_remove = (op_reg == OP_REMOVE);
    end

    assign rsp = rsp_reg;

endmodule

>>> rtl/extendible_hash_index_core.sv
// Extendible hash index: top level joining the sequencer and the datapath.
//
// Each request transaction carries an op (insert, search, remove, update) and a key of up
// to 19 bytes, which ends at its first zero byte. The key is hashed with djb2 (64-bit
// wrap) one byte per cycle; the low global-depth bits of the hash pick
// a directory entry naming a bucket of 64 slots. Every request yields exactly one
// response transaction (status 0 done/found, 1 not found, 2 table full; payload_out is
// the stored reference on a hit, else zero). One transaction is worked at a time.
// Lookups read and compare the bucket's slots one by one (single read port on the slot
// store). A split rehashes every slot of the full bucket with the same byte-serial hash
// unit to move it, sweeps the directory entry by entry to repoint it, and first copies
// every directory entry into the new upper half when the directory doubles. After reset
// the block seeds directory entries and bucket tables 0 and 1 before it takes a request.
// A new request is accepted while the previous response still waits in the output
// register.
module extendible_hash_index_core import ehi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  ehi_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output ehi_rsp_t rsp
);

    ehi_cmd_t  cmd;
    ehi_stat_t stat;

    // sequencer: state machine and response valid
    ehi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: hash, directory, bucket tables, slot store, response register
    ehi_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

>>> rtl/ehi_checker.sv
// Port-level checker of the hash index and its bind to the top level.
`include "assert_macros.svh"

module ehi_checker import ehi_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input ehi_rsp_t rsp
);

    `EHI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
    `EHI_ASSERT_IMP(a_miss_zero, rsp_valid && (rsp.status != ST_OK), rsp.payload_out == 32'd0)
    `EHI_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
    `EHI_ASSERT_IMP(a_rsp_back_idle, $rose(rsp_valid), req_ready)

endmodule

bind extendible_hash_index_core ehi_checker u_ehi_checker (.*);
